// ===== rtl/core/dlr_pkg.sv =====
// dlr_pkg: shared widths, codes and types for the DDA line rasterizer core.
// Used by every module under rtl/core; depends on nothing.
package dlr_pkg;

	localparam int COORD_BITS  = 13;
	localparam int FRAC_BITS   = 16;
	localparam int SCREEN_BITS = 13;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int SLOPE_BITS  = FRAC_BITS + 2;
	localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 3;
	localparam int MINOR_BITS  = ACC_BITS - FRAC_BITS;
	localparam int CMP_BITS    = ((MINOR_BITS > SCREEN_BITS) ? MINOR_BITS : SCREEN_BITS) + 1;
	localparam int CNT_BITS    = $clog2(FRAC_BITS);

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam int CMD_DEPTH    = 2;
	localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH    = 4;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

	localparam logic [SCREEN_BITS-1:0] SCREEN_RESET = SCREEN_BITS'(600);

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_CLASS,
		FS_PREP,
		FS_DIV,
		FS_PUSH
	} front_state_t;

	typedef struct packed {
		logic                         is_start;
		logic                         steep;
		logic signed [COORD_BITS-1:0] maj0;
		logic signed [COORD_BITS-1:0] maj1;
		logic signed [COORD_BITS-1:0] min0;
		logic signed [SLOPE_BITS-1:0] slope;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic                  valid;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  on_scr;
		logic                  last;
	} res_t;

endpackage

// ===== rtl/core/dlr_front.sv =====
// dlr_front: accepts request beats, sorts start endpoints and derives the
// slope with a one-bit-per-cycle restoring divider. Depends on dlr_pkg.
module dlr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                req_type,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end0_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end0_y,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end1_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end1_y,
	input  dlr_pkg::q_status_t                  cmd_status,
	output logic                                cmd_push,
	output dlr_pkg::cmd_t                       cmd
);
	import dlr_pkg::*;

	front_state_t state_q, state_d;

	logic signed [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [COORD_BITS-1:0] maj0_q, maj1_q, min0_q, min1_q;
	logic                         steep_q, neg_q, qhi_q, zero_q;
	logic [DIFF_BITS-1:0]         den_q, rem_q;
	logic [FRAC_BITS-1:0]         quo_q;
	logic [CNT_BITS-1:0]          cnt_q;

	logic                         accept, div_done;
	logic signed [DIFF_BITS-1:0]  dx, dy, num, den_s;
	logic [DIFF_BITS-1:0]         adx, ady, num_abs, den_u, rem_sh, rem_sub;
	logic                         steep_c, swap_c, qbit;
	logic signed [COORD_BITS-1:0] a0, a1, b0, b1;
	logic [FRAC_BITS:0]           slope_mag;
	logic [SLOPE_BITS-1:0]        slope_ext;
	logic signed [SLOPE_BITS-1:0] slope_c;

	assign full     = (state_q != FS_IDLE) || cmd_status.full;
	assign accept   = push && !full;
	assign div_done = (cnt_q == CNT_BITS'(FRAC_BITS - 1));

	// classification
	assign dx      = DIFF_BITS'(x1_q) - DIFF_BITS'(x0_q);
	assign dy      = DIFF_BITS'(y1_q) - DIFF_BITS'(y0_q);
	assign adx     = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
	assign ady     = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
	assign steep_c = !(ady < adx);
	assign a0      = steep_c ? y0_q : x0_q;
	assign a1      = steep_c ? y1_q : x1_q;
	assign b0      = steep_c ? x0_q : y0_q;
	assign b1      = steep_c ? x1_q : y1_q;
	assign swap_c  = a1 < a0;

	// divider setup and step
	assign num     = DIFF_BITS'(min1_q) - DIFF_BITS'(min0_q);
	assign den_s   = DIFF_BITS'(maj1_q) - DIFF_BITS'(maj0_q);
	assign den_u   = DIFF_BITS'(den_s);
	assign num_abs = num[DIFF_BITS-1] ? DIFF_BITS'(-num) : DIFF_BITS'(num);
	assign rem_sh  = {rem_q[DIFF_BITS-2:0], 1'b0};
	assign qbit    = (rem_sh >= den_q);
	assign rem_sub = rem_sh - den_q;

	assign slope_mag = zero_q ? '0 : {qhi_q, quo_q};
	assign slope_ext = {1'b0, slope_mag};
	assign slope_c   = neg_q ? SLOPE_BITS'(-slope_ext) : SLOPE_BITS'(slope_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd_push     = 1'b0;
		cmd.is_start = (state_q == FS_PUSH);
		cmd.steep    = steep_q;
		cmd.maj0     = maj0_q;
		cmd.maj1     = maj1_q;
		cmd.min0     = min0_q;
		cmd.slope    = slope_c;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					if (req_type == REQ_START) begin
						state_d = FS_CLASS;
					end else begin
						cmd_push = 1'b1;
					end
				end
			end
			FS_CLASS: begin
				state_d = FS_PREP;
			end
			FS_PREP: begin
				state_d = FS_DIV;
			end
			FS_DIV: begin
				if (div_done) begin
					state_d = FS_PUSH;
				end
			end
			FS_PUSH: begin
				if (!cmd_status.full) begin
					cmd_push = 1'b1;
					state_d  = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && accept && req_type == REQ_START) begin
			x0_q <= end0_x;
			y0_q <= end0_y;
			x1_q <= end1_x;
			y1_q <= end1_y;
		end
		if (state_q == FS_CLASS) begin
			steep_q <= steep_c;
			maj0_q  <= swap_c ? a1 : a0;
			maj1_q  <= swap_c ? a0 : a1;
			min0_q  <= swap_c ? b1 : b0;
			min1_q  <= swap_c ? b0 : b1;
		end
		if (state_q == FS_PREP) begin
			// |num| <= den: a full-scale ratio is the integer bit alone
			rem_q  <= (num_abs == den_u) ? '0 : num_abs;
			qhi_q  <= (num_abs == den_u) && (den_u != '0);
			zero_q <= (den_u == '0);
			neg_q  <= num[DIFF_BITS-1];
			den_q  <= den_u;
		end
		if (state_q == FS_DIV) begin
			rem_q <= qbit ? rem_sub : rem_sh;
			quo_q <= {quo_q[FRAC_BITS-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == FS_PREP) begin
			cnt_q <= '0;
		end else if (state_q == FS_DIV) begin
			cnt_q <= CNT_BITS'(cnt_q + 1'b1);
		end
	end

endmodule

// ===== rtl/core/dlr_cmd_queue.sv =====
// dlr_cmd_queue: short command queue between the front and the back.
// Depends on dlr_pkg for cmd_t and the queue depth.
module dlr_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dlr_pkg::cmd_t      wr_data,
	input  logic               pop,
	output dlr_pkg::cmd_t      rd_data,
	output dlr_pkg::q_status_t status
);
	import dlr_pkg::*;

	cmd_t                    mem_q [CMD_DEPTH];
	logic [CMD_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_CNT_BITS-1:0] cnt_q;
	logic                    do_push, do_pop;

	assign status.full  = (cnt_q == CMD_CNT_BITS'(CMD_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= CMD_PTR_BITS'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= CMD_PTR_BITS'(rd_ptr_q + 1'b1);
			end
			cnt_q <= CMD_CNT_BITS'(cnt_q + CMD_CNT_BITS'(do_push) - CMD_CNT_BITS'(do_pop));
		end
	end

endmodule

// ===== rtl/core/dlr_back.sv =====
// dlr_back: walks the active line one pixel per command, rounds the minor
// coordinate, checks screen bounds and queues results. Depends on dlr_pkg.
module dlr_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dlr_pkg::q_status_t                   cmd_status,
	input  dlr_pkg::cmd_t                        cmd,
	output logic                                 cmd_pop,
	input  logic [dlr_pkg::SCREEN_BITS-1:0]      screen_width,
	input  logic [dlr_pkg::SCREEN_BITS-1:0]      screen_height,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 pixel_valid,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_y,
	output logic                                 on_screen,
	output logic                                 last_pixel
);
	import dlr_pkg::*;

	localparam logic [ACC_BITS-1:0] FRAC_MASK = ACC_BITS'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [ACC_BITS-1:0] HALF      = ACC_BITS'(64'd1 << (FRAC_BITS - 1));

	logic                         active_q, steep_q;
	logic signed [COORD_BITS-1:0] pos_q, end_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic signed [SLOPE_BITS-1:0] slope_q;
	logic                         pend_s1, pend_null_s1, pend_last_s1;

	res_t                    res_mem_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_CNT_BITS-1:0] res_cnt_q;

	logic                         take, do_pop, last_c, round_neg;
	logic signed [COORD_BITS-1:0] pos_inc;
	logic signed [ACC_BITS-1:0]   acc_half, acc_up, acc_flr;
	logic signed [MINOR_BITS-1:0] minor, pos_w, px, py;
	logic                         on_c;
	res_t                         res_c, res_head;

	assign take    = !cmd_status.empty
		&& (RES_CNT_BITS'(res_cnt_q + RES_CNT_BITS'(pend_s1)) < RES_CNT_BITS'(RES_DEPTH));
	assign cmd_pop = take;
	assign pos_inc = pos_q + COORD_BITS'(1);
	assign last_c  = cmd.is_start ? (cmd.maj0 >= cmd.maj1) : (pos_inc >= end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= take;
			if (take && (cmd.is_start || active_q)) begin
				active_q <= !last_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_null_s1 <= !cmd.is_start && !active_q;
			pend_last_s1 <= last_c;
			if (cmd.is_start) begin
				steep_q <= cmd.steep;
				pos_q   <= cmd.maj0;
				end_q   <= cmd.maj1;
				slope_q <= cmd.slope;
				acc_q   <= {{(ACC_BITS - COORD_BITS - FRAC_BITS){cmd.min0[COORD_BITS-1]}},
					cmd.min0, {FRAC_BITS{1'b0}}};
			end else if (active_q) begin
				pos_q <= pos_inc;
				acc_q <= acc_q + {{(ACC_BITS - SLOPE_BITS){slope_q[SLOPE_BITS-1]}}, slope_q};
			end
		end
	end

	// minor = round(acc + 0.5), ties away from zero
	assign acc_half  = acc_q + HALF;
	assign round_neg = acc_half[ACC_BITS-1];
	assign acc_up    = acc_q + FRAC_MASK;
	assign acc_flr   = acc_q >>> FRAC_BITS;
	always_comb begin
		logic signed [ACC_BITS-1:0] up_sh;
		up_sh = acc_up >>> FRAC_BITS;
		minor = round_neg ? up_sh[MINOR_BITS-1:0]
			: MINOR_BITS'(acc_flr[MINOR_BITS-1:0] + 1'b1);
	end

	assign pos_w = MINOR_BITS'(pos_q);
	assign px    = steep_q ? minor : pos_w;
	assign py    = steep_q ? pos_w : minor;
	assign on_c  = !px[MINOR_BITS-1] && !py[MINOR_BITS-1]
		&& (CMP_BITS'(px) < CMP_BITS'(screen_width))
		&& (CMP_BITS'(py) < CMP_BITS'(screen_height));

	always_comb begin
		res_c = '0;
		if (!pend_null_s1) begin
			res_c.valid  = 1'b1;
			res_c.x      = px[COORD_BITS-1:0];
			res_c.y      = py[COORD_BITS-1:0];
			res_c.on_scr = on_c;
			res_c.last   = pend_last_s1;
		end
	end

	assign empty  = (res_cnt_q == '0);
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			res_mem_q[wr_ptr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (pend_s1) begin
				wr_ptr_q <= RES_PTR_BITS'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= RES_PTR_BITS'(rd_ptr_q + 1'b1);
			end
			res_cnt_q <= RES_CNT_BITS'(res_cnt_q + RES_CNT_BITS'(pend_s1)
				- RES_CNT_BITS'(do_pop));
		end
	end

	assign res_head    = res_mem_q[rd_ptr_q];
	assign pixel_valid = res_head.valid;
	assign pixel_x     = res_head.x;
	assign pixel_y     = res_head.y;
	assign on_screen   = res_head.on_scr;
	assign last_pixel  = res_head.last;

`ifndef SYNTH
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RES_CNT_BITS'(RES_DEPTH))
		else $error("result queue count above depth");

	a_pend_room: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (res_cnt_q < RES_CNT_BITS'(RES_DEPTH)))
		else $error("pixel beat into a full result queue");

	a_idle_null: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !cmd.is_start && !active_q) |=> (pend_s1 && pend_null_s1))
		else $error("advance on idle line did not give an empty beat");

	a_start_live: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.is_start) |=> (pend_s1 && !pend_null_s1))
		else $error("start beat did not give a pixel");
`endif

endmodule

// ===== rtl/core/dda_line_rasterizer_core.sv =====
// Start beat: full stays high after it while the line is classified, the divider is set up and
// makes one quotient bit per cycle, and the command waits for room in the command queue.
// Advance beat: one per cycle while full is low, pushed straight into the command queue.
// Results wait in a 4-entry queue; full follows the 2-entry command queue.
// Reset (arst_n low, async): queues empty, no line active, screen size 600x600.
// Top level: APB registers, front, command queue and back. Depends on dlr_pkg.
module dda_line_rasterizer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dlr_pkg::PADDR_BITS-1:0]       paddr,
	input  logic [dlr_pkg::PDATA_BITS-1:0]       pwdata,
	output logic [dlr_pkg::PDATA_BITS-1:0]       prdata,
	output logic                                 pready,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 req_type,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end0_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end0_y,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end1_x,
	input  logic signed [dlr_pkg::COORD_BITS-1:0] end1_y,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 pixel_valid,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [dlr_pkg::COORD_BITS-1:0] pixel_y,
	output logic                                 on_screen,
	output logic                                 last_pixel
);
	import dlr_pkg::*;

	logic [SCREEN_BITS-1:0] width_q, height_q;
	logic                   reg_idx, wr_en;
	logic                   fe_push, be_pop;
	cmd_t                   fe_cmd, q_cmd;
	q_status_t              q_status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_RESET;
			height_q <= SCREEN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SCREEN_WIDTH:  width_q  <= pwdata[SCREEN_BITS-1:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[SCREEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SCREEN_WIDTH:  prdata = PDATA_BITS'(width_q);
			REG_SCREEN_HEIGHT: prdata = PDATA_BITS'(height_q);
			default:           prdata = '0;
		endcase
	end

	dlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.end0_x     (end0_x),
		.end0_y     (end0_y),
		.end1_x     (end1_x),
		.end1_y     (end1_y),
		.cmd_status (q_status),
		.cmd_push   (fe_push),
		.cmd        (fe_cmd)
	);

	dlr_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fe_push),
		.wr_data (fe_cmd),
		.pop     (be_pop),
		.rd_data (q_cmd),
		.status  (q_status)
	);

	dlr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_status    (q_status),
		.cmd           (q_cmd),
		.cmd_pop       (be_pop),
		.screen_width  (width_q),
		.screen_height (height_q),
		.empty         (empty),
		.pop           (pop),
		.pixel_valid   (pixel_valid),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.on_screen     (on_screen),
		.last_pixel    (last_pixel)
	);

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for dda_line_rasterizer_core (queue-style item and pixel ports, APB).
// Predicts each pixel in-bench; queue driver and pixel monitor are clocked always blocks.
// Depends on rtl/core/dlr_pkg.sv and rtl/core/dda_line_rasterizer_core.sv.
`timescale 1ns / 100ps

module tb_top;

	localparam int CW   = dlr_pkg::COORD_BITS;
	localparam int FB   = dlr_pkg::FRAC_BITS;
	localparam int CMAX = (1 << (CW - 1)) - 1;
	localparam int CMIN = -(1 << (CW - 1));

	typedef struct {
		logic                 kind;
		logic signed [CW-1:0] p0x;
		logic signed [CW-1:0] p0y;
		logic signed [CW-1:0] p1x;
		logic signed [CW-1:0] p1y;
	} line_req_t;

	logic                              clk;
	logic                              arst_n   = 1'b0;
	logic                              psel     = 1'b0;
	logic                              penable  = 1'b0;
	logic                              pwrite   = 1'b0;
	logic [dlr_pkg::PADDR_BITS-1:0]    paddr    = '0;
	logic [dlr_pkg::PDATA_BITS-1:0]    pwdata   = '0;
	logic [dlr_pkg::PDATA_BITS-1:0]    prdata;
	logic                              pready;
	logic                              push     = 1'b0;
	logic                              full;
	logic                              req_type = dlr_pkg::REQ_START;
	logic signed [CW-1:0]              end0_x   = '0;
	logic signed [CW-1:0]              end0_y   = '0;
	logic signed [CW-1:0]              end1_x   = '0;
	logic signed [CW-1:0]              end1_y   = '0;
	logic                              empty;
	logic                              pop      = 1'b0;
	logic                              pixel_valid;
	logic signed [CW-1:0]              pixel_x;
	logic signed [CW-1:0]              pixel_y;
	logic                              on_screen;
	logic                              last_pixel;

	line_req_t     req_backlog[$];
	dlr_pkg::res_t pixel_expect[$];

	// predictor state
	bit     ln_active = 1'b0;
	bit     ln_steep  = 1'b0;
	longint ln_pos    = 0;
	longint ln_end    = 0;
	longint ln_acc    = 0;
	longint ln_slope  = 0;
	longint scr_w     = 600;
	longint scr_h     = 600;

	bit          beat_done = 1'b0;
	bit          calm      = 1'b0;
	int unsigned push_gap  = 0;
	int unsigned pop_hold  = 0;
	int          err_count = 0;
	int          pixels_seen = 0;

	dda_line_rasterizer_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.end0_x     (end0_x),
		.end0_y     (end0_y),
		.end1_x     (end1_x),
		.end1_y     (end1_y),
		.empty      (empty),
		.pop        (pop),
		.pixel_valid(pixel_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.on_screen  (on_screen),
		.last_pixel (last_pixel)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#12_000_000;
		$display("FAIL dda_line_rasterizer_core");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		if (err_count < 40) begin
			$display("ERROR @%0t pixel %0d: %s", $realtime, pixels_seen, msg);
		end
		err_count++;
	endtask

	function automatic int unsigned gap_len();
		int unsigned r;
		if (calm || $urandom_range(0, 1) == 0) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [CW-1:0] clip(input int v);
		if (v > CMAX) v = CMAX;
		if (v < CMIN) v = CMIN;
		return v[CW-1:0];
	endfunction

	function automatic int rand_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25) return int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
		if (r < 55) return int'($urandom_range(0, 48)) - 8;
		return int'($urandom_range(0, 760)) - 40;
	endfunction

	// DDA walk: one pixel per start or advance beat, none for an advance with no line
	function automatic dlr_pkg::res_t raster_step(input line_req_t r);
		dlr_pkg::res_t px;
		longint x0, y0, x1, y1, adx, ady;
		longint maj0, maj1, min0, min1, num, den, mag, tmp;
		longint half, t, minor, cx, cy;
		px = '0;
		half = longint'(1) <<< (FB - 1);
		if (r.kind == dlr_pkg::REQ_START) begin
			x0 = r.p0x;
			y0 = r.p0y;
			x1 = r.p1x;
			y1 = r.p1y;
			adx = (x1 > x0) ? x1 - x0 : x0 - x1;
			ady = (y1 > y0) ? y1 - y0 : y0 - y1;
			ln_steep = !(ady < adx);
			if (ln_steep) begin
				maj0 = y0; maj1 = y1; min0 = x0; min1 = x1;
			end else begin
				maj0 = x0; maj1 = x1; min0 = y0; min1 = y1;
			end
			if (maj1 < maj0) begin
				tmp = maj0; maj0 = maj1; maj1 = tmp;
				tmp = min0; min0 = min1; min1 = tmp;
			end
			num = min1 - min0;
			den = maj1 - maj0;
			if (den == 0) begin
				ln_slope = 0;
			end else begin
				mag = ((num < 0) ? -num : num) <<< FB;
				mag = mag / den;
				ln_slope = (num < 0) ? -mag : mag;
			end
			ln_pos = maj0;
			ln_end = maj1;
			ln_acc = min0 * (longint'(1) <<< FB);
		end else if (!ln_active) begin
			return px;
		end else begin
			ln_pos = ln_pos + 1;
			ln_acc = ln_acc + ln_slope;
		end
		// minor = acc + 1/2, rounded half away from zero
		t = ln_acc + half;
		minor = (t >= 0) ? ((t + half) >>> FB) : -(((-t) + half) >>> FB);
		cx = ln_steep ? minor : ln_pos;
		cy = ln_steep ? ln_pos : minor;
		px.valid  = 1'b1;
		px.x      = cx[CW-1:0];
		px.y      = cy[CW-1:0];
		px.on_scr = (cx >= 0) && (cy >= 0) && (cx < scr_w) && (cy < scr_h);
		px.last   = (ln_pos >= ln_end);
		ln_active = !px.last;
		return px;
	endfunction

	task automatic add_advances(input int n);
		line_req_t q;
		for (int i = 0; i < n; i++) begin
			q.kind = dlr_pkg::REQ_ADVANCE;
			q.p0x  = CW'($urandom);
			q.p0y  = CW'($urandom);
			q.p1x  = CW'($urandom);
			q.p1y  = CW'($urandom);
			req_backlog.insert(req_backlog.size(), q);
		end
	endtask

	task automatic add_line(input int ax, input int ay, input int bx, input int by,
			input int adv);
		line_req_t q;
		q.kind = dlr_pkg::REQ_START;
		q.p0x  = clip(ax);
		q.p0y  = clip(ay);
		q.p1x  = clip(bx);
		q.p1y  = clip(by);
		req_backlog.insert(req_backlog.size(), q);
		add_advances(adv);
	endtask

	task automatic load_random(input int quota);
		int made, ax, ay, bx, by, dx, dy, span, adv;
		int unsigned r;
		made = 0;
		while (made < quota) begin
			r = $urandom_range(0, 99);
			ax = rand_coord();
			ay = rand_coord();
			if (r < 8) begin
				bx = ax;
				by = ay;
			end else if (r < 22) begin
				bx = int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
				by = int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
			end else begin
				bx = int'(clip(ax + int'($urandom_range(0, 48)) - 24));
				by = int'(clip(ay + int'($urandom_range(0, 48)) - 24));
			end
			dx = (bx > ax) ? bx - ax : ax - bx;
			dy = (by > ay) ? by - ay : ay - by;
			span = (dx > dy) ? dx : dy;
			if (span > 30) adv = $urandom_range(0, 8);
			else if ($urandom_range(0, 99) < 80) adv = span + $urandom_range(0, 2);
			else adv = $urandom_range(0, span);
			add_line(ax, ay, bx, by, adv);
			made += 1 + adv;
		end
	endtask

	task automatic write_screen_reg(input logic idx, input int unsigned val);
		logic [dlr_pkg::PDATA_BITS-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == dlr_pkg::REG_SCREEN_WIDTH) scr_w = val;
		else scr_h = val;
		if (rd !== val) note_mismatch($sformatf("reg %0d read %0d wrote %0d", idx, rd, val));
	endtask

	task automatic drain_all();
		while (req_backlog.size() != 0 || push || pixel_expect.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// item driver
	always @(negedge clk) begin
		line_req_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || beat_done) begin
			beat_done = 1'b0;
			if (push_gap > 0) begin
				push_gap--;
				push <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				nxt = req_backlog.pop_front();
				req_type <= nxt.kind;
				end0_x   <= nxt.p0x;
				end0_y   <= nxt.p0y;
				end1_x   <= nxt.p1x;
				end1_y   <= nxt.p1y;
				push     <= 1'b1;
				if ($urandom_range(0, 2) == 0) push_gap = gap_len();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// pixel-side stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 3) == 0) pop_hold = gap_len();
		end
	end

	// monitor
	always @(posedge clk) begin
		line_req_t     got_req;
		dlr_pkg::res_t predicted;
		dlr_pkg::res_t want;
		if (arst_n) begin
			if (push && !full) begin
				got_req = '{req_type, end0_x, end0_y, end1_x, end1_y};
				predicted = raster_step(got_req);
				pixel_expect.insert(pixel_expect.size(), predicted);
				beat_done = 1'b1;
			end
			if (pop && !empty) begin
				if (pixel_expect.size() == 0) begin
					note_mismatch("pixel beat with nothing expected");
				end else begin
					want = pixel_expect.pop_front();
					if (pixel_valid !== want.valid)
						note_mismatch($sformatf("pixel_valid %b exp %b", pixel_valid, want.valid));
					if (pixel_x !== want.x)
						note_mismatch($sformatf("pixel_x %0d exp %0d", pixel_x,
							$signed(want.x)));
					if (pixel_y !== want.y)
						note_mismatch($sformatf("pixel_y %0d exp %0d", pixel_y,
							$signed(want.y)));
					if (on_screen !== want.on_scr)
						note_mismatch($sformatf("on_screen %b exp %b", on_screen, want.on_scr));
					if (last_pixel !== want.last)
						note_mismatch($sformatf("last_pixel %b exp %b", last_pixel, want.last));
				end
				pixels_seen++;
			end
		end
	end

	initial begin
		int unsigned w, h;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: idle advance, single points at the extremes, each walk direction,
		// ties at 45 degrees, vertical, full-span lines cut short by a new start
		add_advances(1);
		add_line(0, 0, 0, 0, 1);
		add_line(CMAX, CMAX, CMAX, CMAX, 0);
		add_line(CMIN, CMIN, CMIN, CMIN, 0);
		add_line(5, 3, 2, 4, 3);
		add_line(3, 4, 2, 1, 3);
		add_line(4, 6, 4, 4, 2);
		add_line(0, 0, -2, 2, 2);
		add_line(CMIN, CMAX, CMAX, CMIN, 1);
		add_line(CMIN, 0, CMAX, 1, 1);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				drain_all();
				case (ph)
					1: begin
						w = 1;
						h = 1;
					end
					2: begin
						w = 4096;
						h = 4096;
					end
					3: begin
						w = 4096;
						h = 1;
					end
					default: begin
						w = $urandom_range(1, 4096);
						h = $urandom_range(1, 4096);
					end
				endcase
				write_screen_reg(dlr_pkg::REG_SCREEN_WIDTH, w);
				write_screen_reg(dlr_pkg::REG_SCREEN_HEIGHT, h);
			end
			calm = (ph == 2);
			load_random(240);
		end
		drain_all();
		if (pixel_expect.size() != 0) note_mismatch("pixels still expected at end");
		if (err_count == 0) begin
			$display("PASS dda_line_rasterizer_core");
		end else begin
			$display("FAIL dda_line_rasterizer_core");
		end
		$finish;
	end

endmodule
